[hw/rtl/ptzd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptzd_pkg
// Shared types and constants for the packed text code decoder.
// ----------------------------------------------------------------------------
package ptzd_pkg;

    localparam int CodeWidth  = 5;
    localparam int WordWidth  = 16;
    localparam int ValueWidth = 7;
    localparam int SlotCount  = 3;

    localparam logic [ValueWidth-1:0] RowLen    = 7'd26;
    localparam logic [ValueWidth-1:0] AlphaBase = 7'd6;

    localparam logic [CodeWidth-1:0] CodeSpace   = 5'd0;
    localparam logic [CodeWidth-1:0] CodeShift1  = 5'd4;
    localparam logic [CodeWidth-1:0] CodeShift2  = 5'd5;
    localparam logic [CodeWidth-1:0] CodeEscape  = 5'd6;
    localparam logic [CodeWidth-1:0] CodeNewline = 5'd7;
    localparam logic [CodeWidth-1:0] CodeAbbrMax = 5'd3;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_ALPHA   = 3'd1,
        KIND_SPACE   = 3'd2,
        KIND_NEWLINE = 3'd3,
        KIND_LITERAL = 3'd4,
        KIND_ABBREV  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ROW_LOWER  = 2'd0,
        ROW_UPPER  = 2'd1,
        ROW_SYMBOL = 2'd2,
        ROW_SPARE  = 2'd3
    } row_t;

    typedef enum logic [1:0] {
        LIT_IDLE = 2'd0,
        LIT_HIGH = 2'd1,
        LIT_LOW  = 2'd2,
        LIT_RSVD = 2'd3
    } lit_phase_t;

    typedef struct packed {
        row_t       locked_mode;
        row_t       oneshot_mode;
        logic       abbrev_pending;
        logic [1:0] abbrev_bank;
        lit_phase_t literal_phase;
        logic [1:0] literal_high_bits;
    } dec_state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [ValueWidth-1:0] value;
    } item_t;

    typedef struct packed {
        logic [1:0]            count;
        logic                  string_end;
        item_t [SlotCount-1:0] items;
    } word_result_t;

endpackage

[hw/rtl/ptzd_code_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptzd_code_step
// Handles one 5-bit code against the decoder state.
// ----------------------------------------------------------------------------
module ptzd_code_step (
    input  logic [ptzd_pkg::CodeWidth-1:0] code,
    input  ptzd_pkg::dec_state_t           state_in,
    output ptzd_pkg::dec_state_t           state_out,
    output logic                           emit,
    output ptzd_pkg::item_t                item
);

    ptzd_pkg::row_t sel;
    ptzd_pkg::row_t shifted;

    always_comb begin
        sel     = (code == ptzd_pkg::CodeShift1) ? ptzd_pkg::ROW_UPPER : ptzd_pkg::ROW_SYMBOL;
        shifted = (state_in.oneshot_mode == sel) ? ptzd_pkg::ROW_LOWER : state_in.oneshot_mode;
    end

    always_comb begin
        state_out  = state_in;
        emit       = 1'b0;
        item.kind  = ptzd_pkg::KIND_NONE;
        item.value = '0;
        if (state_in.abbrev_pending) begin
            emit                      = 1'b1;
            item.kind                 = ptzd_pkg::KIND_ABBREV;
            item.value                = {state_in.abbrev_bank, code};
            state_out.abbrev_pending  = 1'b0;
            state_out.locked_mode     = ptzd_pkg::ROW_LOWER;
            state_out.oneshot_mode    = ptzd_pkg::ROW_LOWER;
        end else if (state_in.literal_phase == ptzd_pkg::LIT_HIGH) begin
            state_out.literal_high_bits = code[1:0];
            state_out.literal_phase     = ptzd_pkg::LIT_LOW;
        end else if (state_in.literal_phase != ptzd_pkg::LIT_IDLE) begin
            emit                    = 1'b1;
            item.kind               = ptzd_pkg::KIND_LITERAL;
            item.value              = {state_in.literal_high_bits, code};
            state_out.literal_phase = ptzd_pkg::LIT_IDLE;
            state_out.oneshot_mode  = state_in.locked_mode;
        end else if (code == ptzd_pkg::CodeSpace) begin
            emit                   = 1'b1;
            item.kind              = ptzd_pkg::KIND_SPACE;
            state_out.oneshot_mode = state_in.locked_mode;
        end else if (code <= ptzd_pkg::CodeAbbrMax) begin
            state_out.abbrev_pending = 1'b1;
            state_out.abbrev_bank    = code[1:0] - 2'd1;
        end else if (code == ptzd_pkg::CodeShift1 || code == ptzd_pkg::CodeShift2) begin
            if (state_in.oneshot_mode == ptzd_pkg::ROW_LOWER) begin
                state_out.oneshot_mode = sel;
            end else begin
                state_out.oneshot_mode = shifted;
                state_out.locked_mode  = shifted;
            end
        end else if (code == ptzd_pkg::CodeEscape
                     && state_in.oneshot_mode == ptzd_pkg::ROW_SYMBOL) begin
            state_out.literal_phase = ptzd_pkg::LIT_HIGH;
        end else if (code == ptzd_pkg::CodeNewline
                     && state_in.oneshot_mode == ptzd_pkg::ROW_SYMBOL) begin
            emit                   = 1'b1;
            item.kind              = ptzd_pkg::KIND_NEWLINE;
            state_out.oneshot_mode = state_in.locked_mode;
        end else begin
            emit                   = 1'b1;
            item.kind              = ptzd_pkg::KIND_ALPHA;
            item.value             = ptzd_pkg::ValueWidth'(state_in.oneshot_mode)
                                     * ptzd_pkg::RowLen
                                     + ptzd_pkg::ValueWidth'(code)
                                     - ptzd_pkg::AlphaBase;
            state_out.oneshot_mode = state_in.locked_mode;
        end
    end

endmodule

[hw/rtl/ptzd_word_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptzd_word_decode
// Runs the three codes of one word in order and packs the emitted items.
// ----------------------------------------------------------------------------
module ptzd_word_decode (
    input  logic [ptzd_pkg::WordWidth-1:0] code_word,
    input  logic                           string_start,
    input  ptzd_pkg::dec_state_t           state_in,
    output ptzd_pkg::dec_state_t           state_out,
    output ptzd_pkg::word_result_t         result
);

    ptzd_pkg::dec_state_t st0;
    ptzd_pkg::dec_state_t st1;
    ptzd_pkg::dec_state_t st2;
    logic                 e0;
    logic                 e1;
    logic                 e2;
    ptzd_pkg::item_t      i0;
    ptzd_pkg::item_t      i1;
    ptzd_pkg::item_t      i2;
    ptzd_pkg::item_t      none_item;

    always_comb begin
        st0 = state_in;
        if (string_start) begin
            st0.locked_mode    = ptzd_pkg::ROW_LOWER;
            st0.oneshot_mode   = ptzd_pkg::ROW_LOWER;
            st0.abbrev_pending = 1'b0;
            st0.literal_phase  = ptzd_pkg::LIT_IDLE;
        end
    end

    ptzd_code_step u_step0 (
        .code      (code_word[14:10]),
        .state_in  (st0),
        .state_out (st1),
        .emit      (e0),
        .item      (i0)
    );

    ptzd_code_step u_step1 (
        .code      (code_word[9:5]),
        .state_in  (st1),
        .state_out (st2),
        .emit      (e1),
        .item      (i1)
    );

    ptzd_code_step u_step2 (
        .code      (code_word[4:0]),
        .state_in  (st2),
        .state_out (state_out),
        .emit      (e2),
        .item      (i2)
    );

    always_comb begin
        none_item.kind  = ptzd_pkg::KIND_NONE;
        none_item.value = '0;
        result.string_end = code_word[ptzd_pkg::WordWidth-1];
        result.count      = 2'(e0) + 2'(e1) + 2'(e2);
        if (!(e0 || e1 || e2)) begin
            result.count = 2'd1;
        end
        if (e0) begin
            result.items[0] = i0;
        end else if (e1) begin
            result.items[0] = i1;
        end else if (e2) begin
            result.items[0] = i2;
        end else begin
            result.items[0] = none_item;
        end
        result.items[1] = (e0 && e1) ? i1 : i2;
        result.items[2] = i2;
    end

endmodule

[hw/rtl/ptzd_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptzd_out_queue
// Holds one word's items and presents one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module ptzd_out_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  ptzd_pkg::word_result_t         result,
    output logic                           can_load,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_out_kind,
    output logic [ptzd_pkg::ValueWidth-1:0] m_out_value,
    output logic                           m_string_end,
    output logic                           m_last_of_word
);

    logic [1:0]                                cnt_reg;
    logic [1:0]                                cnt_next;
    logic                                      end_reg;
    ptzd_pkg::item_t [ptzd_pkg::SlotCount-1:0] items_reg;
    logic                                      pop;

    assign m_valid        = (cnt_reg != 2'd0);
    assign pop            = m_valid && m_ready;
    assign can_load       = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign m_out_kind     = items_reg[0].kind;
    assign m_out_value    = items_reg[0].value;
    assign m_string_end   = end_reg;
    assign m_last_of_word = (cnt_reg == 2'd1);

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = result.count;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            items_reg <= result.items;
            end_reg   <= result.string_end;
        end else if (pop) begin
            items_reg[0] <= items_reg[1];
            items_reg[1] <= items_reg[2];
        end
    end

endmodule

[hw/rtl/packed_text_zchar_decoder_top.sv]
`timescale 1ns / 1ps
// An accepted word is held in the input register, decoded combinationally and
// loaded into the output queue registers once the queue can take it. A word
// that yields n items (1 to 3) holds the result port until all are taken,
// while the input register can take the next word; the single result port
// is the limit. Reset (aresetn low, synchronous) empties both registers and
// clears all alphabet, abbreviation and literal state to zero.
// ----------------------------------------------------------------------------
// packed_text_zchar_decoder_top
// Decodes packed 16-bit text words into character, literal and
// abbreviation items.
// ----------------------------------------------------------------------------
module packed_text_zchar_decoder_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ptzd_pkg::WordWidth-1:0]  s_code_word,
    input  logic                            s_string_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_out_kind,
    output logic [ptzd_pkg::ValueWidth-1:0] m_out_value,
    output logic                            m_string_end,
    output logic                            m_last_of_word
);

    logic                           full_reg;
    logic                           full_next;
    logic [ptzd_pkg::WordWidth-1:0] word_reg;
    logic                           start_reg;
    ptzd_pkg::dec_state_t           state_reg;
    ptzd_pkg::dec_state_t           state_next;
    ptzd_pkg::word_result_t         result;
    logic                           can_load;
    logic                           load;
    logic                           s_fire;

    assign load    = full_reg && can_load;
    assign s_ready = !full_reg || load;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        full_next = full_reg;
        if (s_fire) begin
            full_next = 1'b1;
        end else if (load) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg  <= 1'b0;
            state_reg <= '0;
        end else begin
            full_reg <= full_next;
            if (load) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            word_reg  <= s_code_word;
            start_reg <= s_string_start;
        end
    end

    ptzd_word_decode u_decode (
        .code_word    (word_reg),
        .string_start (start_reg),
        .state_in     (state_reg),
        .state_out    (state_next),
        .result       (result)
    );

    ptzd_out_queue u_queue (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load),
        .result         (result),
        .can_load       (can_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_value    (m_out_value),
        .m_string_end   (m_string_end),
        .m_last_of_word (m_last_of_word)
    );

endmodule

[test/tb_packed_text_zchar_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_text_zchar_decoder_top
// Self-checking bench for the packed text code decoder. A directed set of
// words covers spaces, the lower and upper alphabet rows, shifts and locks,
// newlines, two-code literals, every abbreviation bank, words with no
// character and state carried across string boundaries. Random strings
// follow. A scoreboard predicts the items of each accepted word and checks
// every item in order; both channels stall at random before the calm tail.
// ----------------------------------------------------------------------------
module tb_packed_text_zchar_decoder_top;

    localparam logic [ptzd_pkg::CodeWidth-1:0] CodeAbbr0 = 5'd1;
    localparam logic [ptzd_pkg::CodeWidth-1:0] CodeAbbr1 = 5'd2;
    localparam logic [ptzd_pkg::CodeWidth-1:0] CodeAbbr2 = ptzd_pkg::CodeAbbrMax;
    localparam int RandomWords = 108;
    localparam int CalmTail    = 80;
    localparam int StallLimit  = 2000;

    typedef struct {
        ptzd_pkg::kind_t                 kind;
        logic [ptzd_pkg::ValueWidth-1:0] value;
        logic                            string_end;
        logic                            last_of_word;
    } expected_item_t;

    class zchar_scoreboard;
        ptzd_pkg::row_t       locked_row;
        ptzd_pkg::row_t       oneshot_row;
        logic                 abbr_waiting;
        logic [1:0]           abbr_bank;
        ptzd_pkg::lit_phase_t lit_phase;
        logic [1:0]           lit_high;
        expected_item_t       expected_items[$];
        int                   mismatch_count;

        function new();
            locked_row     = ptzd_pkg::ROW_LOWER;
            oneshot_row    = ptzd_pkg::ROW_LOWER;
            abbr_waiting   = 1'b0;
            abbr_bank      = 2'd0;
            lit_phase      = ptzd_pkg::LIT_IDLE;
            lit_high       = 2'd0;
            mismatch_count = 0;
        endfunction

        function bit decode_code(input logic [ptzd_pkg::CodeWidth-1:0] c,
                                 output ptzd_pkg::item_t it);
            ptzd_pkg::row_t sel;
            it.kind  = ptzd_pkg::KIND_NONE;
            it.value = '0;
            if (abbr_waiting) begin
                it.kind      = ptzd_pkg::KIND_ABBREV;
                it.value     = {abbr_bank, c};
                abbr_waiting = 1'b0;
                locked_row   = ptzd_pkg::ROW_LOWER;
                oneshot_row  = ptzd_pkg::ROW_LOWER;
                return 1'b1;
            end
            if (lit_phase == ptzd_pkg::LIT_HIGH) begin
                lit_high  = c[1:0];
                lit_phase = ptzd_pkg::LIT_LOW;
                return 1'b0;
            end
            if (lit_phase != ptzd_pkg::LIT_IDLE) begin
                it.kind     = ptzd_pkg::KIND_LITERAL;
                it.value    = {lit_high, c};
                lit_phase   = ptzd_pkg::LIT_IDLE;
                oneshot_row = locked_row;
                return 1'b1;
            end
            if (c == ptzd_pkg::CodeSpace) begin
                it.kind     = ptzd_pkg::KIND_SPACE;
                oneshot_row = locked_row;
                return 1'b1;
            end
            if (c <= ptzd_pkg::CodeAbbrMax) begin
                abbr_waiting = 1'b1;
                abbr_bank    = 2'(c - 5'd1);
                return 1'b0;
            end
            if (c == ptzd_pkg::CodeShift1 || c == ptzd_pkg::CodeShift2) begin
                sel = (c == ptzd_pkg::CodeShift1) ? ptzd_pkg::ROW_UPPER : ptzd_pkg::ROW_SYMBOL;
                if (oneshot_row == ptzd_pkg::ROW_LOWER) begin
                    oneshot_row = sel;
                end else begin
                    if (oneshot_row == sel) oneshot_row = ptzd_pkg::ROW_LOWER;
                    locked_row = oneshot_row;
                end
                return 1'b0;
            end
            if (c == ptzd_pkg::CodeEscape && oneshot_row == ptzd_pkg::ROW_SYMBOL) begin
                lit_phase = ptzd_pkg::LIT_HIGH;
                return 1'b0;
            end
            if (c == ptzd_pkg::CodeNewline && oneshot_row == ptzd_pkg::ROW_SYMBOL) begin
                it.kind     = ptzd_pkg::KIND_NEWLINE;
                oneshot_row = locked_row;
                return 1'b1;
            end
            it.kind     = ptzd_pkg::KIND_ALPHA;
            it.value    = ptzd_pkg::ValueWidth'(int'(oneshot_row) * int'(ptzd_pkg::RowLen)
                                                + int'(c) - int'(ptzd_pkg::AlphaBase));
            oneshot_row = locked_row;
            return 1'b1;
        endfunction

        function void note_word(input logic [ptzd_pkg::WordWidth-1:0] w, input logic st);
            ptzd_pkg::item_t it;
            expected_item_t  e;
            int              first;
            first = expected_items.size();
            if (st) begin
                locked_row   = ptzd_pkg::ROW_LOWER;
                oneshot_row  = ptzd_pkg::ROW_LOWER;
                abbr_waiting = 1'b0;
                lit_phase    = ptzd_pkg::LIT_IDLE;
            end
            for (int i = ptzd_pkg::SlotCount - 1; i >= 0; i--) begin
                if (decode_code(w[i*ptzd_pkg::CodeWidth +: ptzd_pkg::CodeWidth], it)) begin
                    e.kind         = it.kind;
                    e.value        = it.value;
                    e.string_end   = w[ptzd_pkg::WordWidth-1];
                    e.last_of_word = 1'b0;
                    expected_items.push_back(e);
                end
            end
            if (expected_items.size() == first) begin
                e.kind         = ptzd_pkg::KIND_NONE;
                e.value        = '0;
                e.string_end   = w[ptzd_pkg::WordWidth-1];
                e.last_of_word = 1'b0;
                expected_items.push_back(e);
            end
            expected_items[expected_items.size()-1].last_of_word = 1'b1;
        endfunction

        function void check_item(input logic [2:0] kind,
                                 input logic [ptzd_pkg::ValueWidth-1:0] value,
                                 input logic send, input logic last);
            expected_item_t e;
            if (expected_items.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word kind=%0d value=%0d end=%0d last=%0d",
                         $time, kind, value, send, last);
                return;
            end
            e = expected_items.pop_front();
            if (kind !== e.kind || value !== e.value || send !== e.string_end
                    || last !== e.last_of_word) begin
                mismatch_count++;
                $display("%0t: expected kind=%0d value=%0d end=%0d last=%0d, %s%0d %0d %0d %0d",
                         $time, e.kind, e.value, e.string_end, e.last_of_word,
                         "actual kind/value/end/last=", kind, value, send, last);
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [ptzd_pkg::WordWidth-1:0]  s_code_word;
    logic                            s_string_start;
    logic                            m_valid;
    logic                            m_ready;
    logic [2:0]                      m_out_kind;
    logic [ptzd_pkg::ValueWidth-1:0] m_out_value;
    logic                            m_string_end;
    logic                            m_last_of_word;

    zchar_scoreboard sb;
    bit              idle_on;
    int              idle_cycles;
    int              random_words;

    packed_text_zchar_decoder_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_word    (s_code_word),
        .s_string_start (s_string_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_value    (m_out_value),
        .m_string_end   (m_string_end),
        .m_last_of_word (m_last_of_word)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic logic [ptzd_pkg::WordWidth-1:0] pack_codes(input logic fin,
            input logic [ptzd_pkg::CodeWidth-1:0] a, input logic [ptzd_pkg::CodeWidth-1:0] b,
            input logic [ptzd_pkg::CodeWidth-1:0] c);
        return {fin, a, b, c};
    endfunction

    function automatic logic [ptzd_pkg::CodeWidth-1:0] pick_code();
        if ($urandom_range(0, 9) < 6) return ptzd_pkg::CodeWidth'($urandom_range(0, 7));
        return ptzd_pkg::CodeWidth'($urandom_range(0, 31));
    endfunction

    task automatic send_word(input logic [ptzd_pkg::WordWidth-1:0] w, input logic st);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_code_word    <= w;
        s_string_start <= st;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w, st);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_items.size() != 0) @(negedge aclk);
    endtask

    task automatic send_string();
        int   len;
        logic st;
        logic fin;
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_word(ptzd_pkg::WordWidth'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)));
            end else begin
                st  = (k == 0) && ($urandom_range(0, 7) != 0);
                fin = (k == len - 1) && ($urandom_range(0, 7) != 0);
                send_word(pack_codes(fin, pick_code(), pick_code(), pick_code()), st);
            end
            random_words++;
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_item(m_out_kind, m_out_value, m_string_end, m_last_of_word);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= StallLimit) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial begin
        sb             = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_code_word    = '0;
        s_string_start = 1'b0;
        idle_on        = 1'b1;
        idle_cycles    = 0;
        random_words   = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_word(pack_codes(1'b0, ptzd_pkg::CodeSpace, ptzd_pkg::CodeSpace,
                             ptzd_pkg::CodeSpace), 1'b1);
        send_word(pack_codes(1'b0, 5'd6, 5'd31, 5'd7), 1'b0);
        send_word(pack_codes(1'b0, ptzd_pkg::CodeShift1, 5'd6, 5'd31), 1'b0);
        send_word(pack_codes(1'b0, ptzd_pkg::CodeShift2, ptzd_pkg::CodeNewline,
                             ptzd_pkg::CodeShift2), 1'b0);
        send_word(pack_codes(1'b0, ptzd_pkg::CodeEscape, 5'd31, 5'd31), 1'b0);
        send_word(pack_codes(1'b0, ptzd_pkg::CodeShift2, ptzd_pkg::CodeEscape, 5'd0), 1'b0);
        send_word(pack_codes(1'b0, 5'd0, ptzd_pkg::CodeSpace, 5'd20), 1'b0);
        send_word(pack_codes(1'b0, CodeAbbr0, 5'd0, CodeAbbr1), 1'b0);
        send_word(pack_codes(1'b0, 5'd31, CodeAbbr2, 5'd31), 1'b0);
        send_word(pack_codes(1'b0, ptzd_pkg::CodeShift1, ptzd_pkg::CodeShift2, 5'd6), 1'b0);
        send_word(pack_codes(1'b0, 5'd6, ptzd_pkg::CodeSpace, 5'd6), 1'b0);
        send_word(pack_codes(1'b0, ptzd_pkg::CodeShift1, 5'd6, ptzd_pkg::CodeSpace), 1'b0);
        send_word(pack_codes(1'b0, ptzd_pkg::CodeShift2, ptzd_pkg::CodeShift1,
                             ptzd_pkg::CodeNewline), 1'b0);
        send_word(pack_codes(1'b0, ptzd_pkg::CodeEscape, 5'd1, 5'd2), 1'b0);
        send_word(pack_codes(1'b0, CodeAbbr2, 5'd5, 5'd8), 1'b0);
        send_word(pack_codes(1'b0, ptzd_pkg::CodeShift1, ptzd_pkg::CodeShift2,
                             ptzd_pkg::CodeShift1), 1'b0);
        send_word(pack_codes(1'b1, ptzd_pkg::CodeShift1, ptzd_pkg::CodeShift2, CodeAbbr0),
                  1'b0);
        send_word(pack_codes(1'b0, 5'd9, ptzd_pkg::CodeSpace, ptzd_pkg::CodeSpace), 1'b0);
        send_word(pack_codes(1'b1, ptzd_pkg::CodeShift2, ptzd_pkg::CodeEscape, 5'd3), 1'b0);
        send_word(pack_codes(1'b0, 5'd8, ptzd_pkg::CodeShift2, ptzd_pkg::CodeEscape), 1'b1);
        send_word(pack_codes(1'b0, 5'd2, 5'd17, 5'd12), 1'b1);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h8000, 1'b0);
        wait_drained();

        while (random_words < RandomWords) begin
            if (random_words >= CalmTail) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            send_string();
            if (random_words >= RandomWords / 2 && random_words < RandomWords / 2 + 6)
                wait_drained();
        end
        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.expected_items.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/ptzd_pkg.sv
hw/rtl/ptzd_code_step.sv
hw/rtl/ptzd_word_decode.sv
hw/rtl/ptzd_out_queue.sv
hw/rtl/packed_text_zchar_decoder_top.sv
test/tb_packed_text_zchar_decoder_top.sv
